[hdl/cfa_pkg.sv]
`timescale 1ns / 1ps

package cfa_pkg;

  // CRC-16/MODBUS: reflected polynomial, all-ones start, no final XOR
  localparam logic [15:0] CRC_START = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Trailer sequencer codes: CRC bytes still owed after the current result
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_HI   = 2'd1;
  localparam logic [1:0] PEND_LO   = 2'd2;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_crc;
    logic       last_of_run;
  } out_item_t;

  // Handover from the input register to the output stage
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        trailer;   // frame end with append on
    logic [15:0] crc;       // CRC including this byte
  } load_t;

  // Fold one byte into the CRC, LSB first, eight shift/XOR steps
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                           input logic [7:0]  byte_in);
    logic [15:0] c;
    c = crc_in ^ {8'h00, byte_in};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/cfa_crc_unit.sv]
`timescale 1ns / 1ps

module cfa_crc_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic [15:0] crc_new
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  // Running CRC folded with the byte in the input register
  assign crc_new = cfa_pkg::crc_fold(crc_r, data_byte);

  // Restart at the end of every frame
  always_comb begin
    crc_nxt = crc_r;
    if (step) begin
      crc_nxt = frame_end ? cfa_pkg::CRC_START : crc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= cfa_pkg::CRC_START;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

[hdl/cfa_out_stage.sv]
`timescale 1ns / 1ps

module cfa_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_valid,
  input  cfa_pkg::load_t      ld,
  output logic                ld_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output cfa_pkg::out_item_t  out_data
);

  logic               out_valid_r;
  logic               out_valid_nxt;
  cfa_pkg::out_item_t out_data_r;
  cfa_pkg::out_item_t out_data_nxt;
  logic [1:0]         pend_r;
  logic [1:0]         pend_nxt;
  logic [15:0]        crc_hold_r;
  logic [15:0]        crc_hold_nxt;
  logic               out_fire;

  assign out_fire = out_valid_r & ~out_stall;
  // Free for a new byte once the current result and its trailer are gone
  assign ld_ready = ~out_valid_r | (out_fire & (pend_r == cfa_pkg::PEND_NONE));

  // Result register and trailer sequencer
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    crc_hold_nxt  = crc_hold_r;
    if (ld_ready && ld_valid) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_byte    = ld.data_byte;
      out_data_nxt.is_crc      = 1'b0;
      out_data_nxt.last_of_run = ~ld.trailer;
      pend_nxt     = ld.trailer ? cfa_pkg::PEND_LO : cfa_pkg::PEND_NONE;
      crc_hold_nxt = ld.crc;
    end else if (out_fire) begin
      case (pend_r)
        cfa_pkg::PEND_LO: begin
          out_data_nxt.out_byte    = crc_hold_r[7:0];
          out_data_nxt.is_crc      = 1'b1;
          out_data_nxt.last_of_run = 1'b0;
          pend_nxt                 = cfa_pkg::PEND_HI;
        end
        cfa_pkg::PEND_HI: begin
          out_data_nxt.out_byte    = crc_hold_r[15:8];
          out_data_nxt.is_crc      = 1'b1;
          out_data_nxt.last_of_run = 1'b1;
          pend_nxt                 = cfa_pkg::PEND_NONE;
        end
        default: begin
          out_valid_nxt = 1'b0;
          pend_nxt      = cfa_pkg::PEND_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= cfa_pkg::PEND_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    crc_hold_r <= crc_hold_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/crc16_frame_append.sv]
`timescale 1ns / 1ps

// Byte stream pass-through with a CRC-16/MODBUS trailer (poly 0xA001 reflected,
// start 0xFFFF, no final XOR). Every input byte comes out unchanged; with
// append_crc set (reset value 1) the last byte of a frame is followed by the
// CRC low byte, then the high byte, both flagged is_crc. last_of_run marks the
// final result of each input byte. The CRC restarts at 0xFFFF after every
// frame end, whether or not the trailer is appended. Throughput is one byte
// per clock while out_stall is low; a frame end with append on holds the
// output register until both CRC bytes have left, and the input stalls
// meanwhile. Data flows through the input register, then the result register.
// Write append_crc only while the block is idle; cfg_ready is always high.
module crc16_frame_append (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cfa_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic              append_crc_r;
  logic              append_crc_nxt;
  logic              in_valid_r;
  logic              in_valid_nxt;
  cfa_pkg::in_item_t in_data_r;
  cfa_pkg::in_item_t in_data_nxt;
  logic              in_fire;
  logic              advance;
  logic              ld_ready;
  logic [15:0]       crc_new;
  cfa_pkg::load_t    ld;

  // Configuration register
  assign cfg_ready      = 1'b1;
  assign append_crc_nxt = (cfg_valid && cfg_ready) ? cfg_data : append_crc_r;

  // Input register
  assign advance  = in_valid_r & ld_ready;
  assign in_stall = in_valid_r & ~ld_ready;
  assign in_fire  = in_valid & ~in_stall;

  always_comb begin
    in_valid_nxt = in_fire | (in_valid_r & ~advance);
    in_data_nxt  = in_fire ? in_data : in_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      append_crc_r <= 1'b1;
      in_valid_r   <= 1'b0;
    end else begin
      append_crc_r <= append_crc_nxt;
      in_valid_r   <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r <= in_data_nxt;
  end

  // CRC accumulator
  cfa_crc_unit u_crc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_data_r.data_byte),
    .frame_end (in_data_r.frame_end),
    .crc_new   (crc_new)
  );

  // Handover to the output stage
  always_comb begin
    ld.data_byte = in_data_r.data_byte;
    ld.trailer   = in_data_r.frame_end & append_crc_r;
    ld.crc       = crc_new;
  end

  cfa_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld_valid  (in_valid_r),
    .ld        (ld),
    .ld_ready  (ld_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
